// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/b64le_pkg.sv -----
package b64le_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [5:0] GPL_RESET = 6'd19;

  localparam logic [6:0] PAD_CHAR = 7'd61;
  localparam logic [6:0] CR_CHAR  = 7'd13;
  localparam logic [6:0] LF_CHAR  = 7'd10;

  typedef struct packed {
    logic [3:0][6:0] chars;
    logic            crlf;
    logic            last;
  } b64le_group_t;

  typedef struct packed {
    logic empty;
    logic full;
  } b64le_qstat_t;

  function automatic logic [6:0] b64_symbol(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + 7'd65;
    end else if (v < 6'd52) begin
      return w + 7'd71;
    end else if (v < 6'd62) begin
      return w - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

// ----- hdl/base64_line_encoder.sv -----
// Streaming Base64 encoder with CR LF line breaks.
// Input channel: one message byte per transaction (data_byte_i), final_byte_i
// on the last byte of a message. Output channel: one ASCII character per
// transaction (out_char_o), last_char_o on the final character of a message.
// A transaction completes on a rising edge where valid is high and stall low.
// Throughput: one character per cycle on the output while a group is queued
// and out_stall_i is low; the output side sets the pace, so a three-byte group
// gives four characters, or six when a CR LF follows it.
// The edge that takes the byte closing a group writes the group into the queue;
// its characters then leave, after earlier groups, via the output register.
// A two-entry group queue parts the byte collector from the character
// serializer; in_stall_o rises only while that queue is full, so a stalled
// receiver backs up the queue and then the input, and no character is lost.
// groups_per_line (APB, address 0, reset 19) sets groups per line; write it
// only while idle. Reset clears held bytes, line position and the queue.
module base64_line_encoder
  import b64le_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  out_char_o,
  output logic        last_char_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]   gpl_q;
  logic         accept;
  logic         push, pop;
  b64le_group_t group_in, head;
  b64le_qstat_t qstat;

  assign pready     = 1'b1;
  assign prdata     = (paddr == 2'd0) ? {26'd0, gpl_q} : 32'd0;
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpl_q <= GPL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      gpl_q <= pwdata[5:0];
    end
  end

  b64le_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .final_byte_i      (final_byte_i),
    .groups_per_line_i (gpl_q),
    .push_o            (push),
    .group_o           (group_in)
  );

  b64le_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (group_in),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  b64le_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ----- hdl/b64le_front.sv -----
module b64le_front
  import b64le_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   data_byte_i,
  input  logic         final_byte_i,
  input  logic [5:0]   groups_per_line_i,
  output logic         push_o,
  output b64le_group_t group_o
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [5:0]  gil_q, gil_d;
  logic        group_done;
  logic [7:0]  b0, b1, b2;
  logic [5:0]  gil_inc;
  logic        crlf;

  assign group_done = final_byte_i || (cnt_q == 2'd2);
  assign push_o     = accept_i && group_done;

  always_comb begin
    b0 = (cnt_q == 2'd0) ? data_byte_i : pend_q[15:8];
    b1 = (cnt_q == 2'd0) ? 8'd0 : ((cnt_q == 2'd1) ? data_byte_i : pend_q[7:0]);
    b2 = (cnt_q == 2'd2) ? data_byte_i : 8'd0;
    gil_inc = gil_q + 6'd1;
    crlf = (gil_inc >= groups_per_line_i) || (gil_inc == 6'd0);
    group_o.chars[0] = b64_symbol(b0[7:2]);
    group_o.chars[1] = b64_symbol({b0[1:0], b1[7:4]});
    group_o.chars[2] = (cnt_q != 2'd0) ? b64_symbol({b1[3:0], b2[7:6]}) : PAD_CHAR;
    group_o.chars[3] = (cnt_q == 2'd2) ? b64_symbol(b2[5:0]) : PAD_CHAR;
    group_o.crlf = crlf;
    group_o.last = final_byte_i;
  end

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    gil_d  = gil_q;
    if (accept_i) begin
      if (group_done) begin
        cnt_d = 2'd0;
        gil_d = (crlf || final_byte_i) ? 6'd0 : gil_inc;
      end else begin
        if (cnt_q == 2'd0) begin
          pend_d = {data_byte_i, 8'd0};
        end else begin
          pend_d = {pend_q[15:8], data_byte_i};
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      gil_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
      gil_q <= gil_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

// ----- hdl/b64le_queue.sv -----
module b64le_queue
  import b64le_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  b64le_group_t entry_i,
  input  logic         pop_i,
  output b64le_group_t head_o,
  output b64le_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64le_group_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntFull);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && stat_o.full)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && stat_o.empty)
  `ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CntW'(1))

endmodule

// ----- hdl/b64le_back.sv -----
module b64le_back
  import b64le_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  b64le_group_t head_i,
  input  b64le_qstat_t stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [6:0]   out_char_o,
  output logic         last_char_o
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] idx_end;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       last_q, last_d;
  logic       advance;
  logic [6:0] sel_char;

  assign advance = !out_valid_q || !out_stall_i;
  assign idx_end = head_i.crlf ? 3'd5 : 3'd3;
  assign pop_o   = advance && !stat_i.empty && (idx_q == idx_end);

  always_comb begin
    case (idx_q)
      3'd4:    sel_char = CR_CHAR;
      3'd5:    sel_char = LF_CHAR;
      default: sel_char = head_i.chars[idx_q[1:0]];
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = !stat_i.empty;
      if (!stat_i.empty) begin
        out_char_d = sel_char;
        last_d     = head_i.last && (idx_q == idx_end);
        idx_d      = (idx_q == idx_end) ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

endmodule

// ----- tb/sv/base64_line_encoder_test.sv -----
`timescale 1ns / 100ps

module base64_line_encoder_test;
  import b64le_pkg::*;

  localparam logic [1:0] GPL_ADDR = 2'd0;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam bit [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_char_t;

  typedef struct {
    int         wr_len;
    logic [7:0] data;
    logic       fin;
    bit         typed;
    string      chars;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  out_char_o;
  logic        last_char_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b1;
  logic [1:0]  paddr = GPL_ADDR;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  logic [5:0]  line_len = GPL_RESET;
  logic [15:0] held_bytes = 16'h0;
  logic [1:0]  held_cnt = 2'd0;
  logic [5:0]  line_groups = 6'd0;
  logic [6:0]  enc_chars [6];
  int          enc_n;

  b64_char_t   char_q [$];
  b64_char_t   oldest;
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{-1, 8'h00, 1'b1, 1'b1, "AA=="},
    '{-1, 8'hFF, 1'b1, 1'b1, "/w=="},
    '{-1, 8'h00, 1'b0, 1'b1, ""},
    '{-1, 8'h00, 1'b1, 1'b1, "AAA="},
    '{-1, 8'hFF, 1'b0, 1'b1, ""},
    '{-1, 8'hFF, 1'b1, 1'b1, "//8="},
    '{-1, 8'hFF, 1'b0, 1'b1, ""},
    '{-1, 8'hFF, 1'b0, 1'b1, ""},
    '{-1, 8'hFF, 1'b1, 1'b1, "////"},
    '{-1, 8'h4D, 1'b0, 1'b1, ""},
    '{-1, 8'h61, 1'b0, 1'b1, ""},
    '{-1, 8'h6E, 1'b1, 1'b1, "TWFu"},
    '{ 0, 8'h00, 1'b0, 1'b1, ""},
    '{-1, 8'h10, 1'b0, 1'b1, ""},
    '{-1, 8'h83, 1'b1, 1'b1, "ABCD\015\012"},
    '{63, 8'h01, 1'b0, 1'b0, ""},
    '{-1, 8'h02, 1'b0, 1'b0, ""},
    '{-1, 8'h03, 1'b0, 1'b0, ""},
    '{-1, 8'h04, 1'b0, 1'b0, ""},
    '{-1, 8'h05, 1'b0, 1'b0, ""},
    '{-1, 8'h06, 1'b0, 1'b0, ""},
    '{ 1, 8'h07, 1'b0, 1'b0, ""},
    '{-1, 8'h08, 1'b0, 1'b0, ""},
    '{-1, 8'h09, 1'b1, 1'b0, ""}
  };

  base64_line_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    return B64_ALPHABET[v][6:0];
  endfunction

  function automatic void push_char(input logic [6:0] c, input logic l);
    b64_char_t item;
    item.ch = c;
    item.last = l;
    char_q.push_back(item);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    int grp_len;
    enc_n = 0;
    if (!fin && held_cnt < 2'd2) begin
      if (held_cnt == 2'd0) held_bytes = {b, 8'h00};
      else held_bytes[7:0] = b;
      held_cnt = held_cnt + 2'd1;
      return;
    end
    grp_len = int'(held_cnt) + 1;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    b2 = 8'h00;
    case (grp_len)
      1: begin
        b0 = b;
        b1 = 8'h00;
      end
      2: b1 = b;
      default: b2 = b;
    endcase
    enc_chars[0] = b64_sym(b0[7:2]);
    enc_chars[1] = b64_sym({b0[1:0], b1[7:4]});
    enc_chars[2] = (grp_len >= 2) ? b64_sym({b1[3:0], b2[7:6]}) : PAD_CHAR;
    enc_chars[3] = (grp_len == 3) ? b64_sym(b2[5:0]) : PAD_CHAR;
    enc_n = 4;
    held_bytes = 16'h0;
    held_cnt = 2'd0;
    line_groups = line_groups + 6'd1;
    if (line_groups >= line_len || line_groups == 6'd0) begin
      enc_chars[4] = CR_CHAR;
      enc_chars[5] = LF_CHAR;
      enc_n = 6;
      line_groups = 6'd0;
    end
    if (fin) line_groups = 6'd0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input string chars);
    byte c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(b, fin);
    if (typed) begin
      for (int k = 0; k < chars.len(); k++) begin
        c = chars[k];
        push_char(c[6:0], fin && k == chars.len() - 1);
      end
    end else begin
      for (int k = 0; k < enc_n; k++) push_char(enc_chars[k], fin && k == enc_n - 1);
    end
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(255));
      send_byte(b, i == len - 1, 1'b0, "");
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (char_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_line_len(input logic [5:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GPL_ADDR;
    pwdata <= {26'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    line_len = v;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 38;
        recv_stall_pct = 38;
      end
    endcase
  endtask

  // receiver: random stall, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (char_q.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, got char %h last %b",
                 $time, out_char_o, last_char_o);
        errors++;
      end else begin
        oldest = char_q.pop_front();
        if (oldest.ch !== out_char_o) begin
          $display("%0t: out_char mismatch: expected %h, got %h",
                   $time, oldest.ch, out_char_o);
          errors++;
        end
        if (oldest.last !== last_char_o) begin
          $display("%0t: last_char mismatch: expected %b, got %b",
                   $time, oldest.last, last_char_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int phase_lens [NUM_PHASES];
    int budget;
    int sent;
    int len;
    bit paused;
    phase_lens = '{1, 2, 63, 0, 19, 0};
    phase_lens[5] = $urandom_range(3, 62);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle(IDLE_NONE);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_len >= 0) begin
        drain();
        write_line_len(dir_rows[i].wr_len[5:0]);
      end
      send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].chars);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_line_len(phase_lens[p][5:0]);
      set_idle(idle_mode_e'(p % 4));
      sent = 0;
      budget = 40;
      paused = 1'b0;
      if (phase_lens[p] == 63) begin
        // hold off the receiver so the encoder backs up while the sender keeps offering
        hold_req = 1'b1;
        send_message(192);
        sent = 192;
        budget = 200;
      end
      while (sent < budget) begin
        if (p == 4 && !paused && sent >= budget / 2) begin
          drain();
          paused = 1'b1;
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_message(len);
        sent += len;
      end
    end

    drain();
    if (errors == 0 && char_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/b64le_pkg.sv
hdl/b64le_front.sv
hdl/b64le_queue.sv
hdl/b64le_back.sv
hdl/base64_line_encoder.sv
tb/sv/base64_line_encoder_test.sv
